>>> rtl/slfr_pkg.sv
// Package for the sync-word length-prefixed frame receiver.
// Holds protocol constants, frame limits and the result word type.
// No dependencies.
package slfr_pkg;

    localparam int unsigned FRAME_CAPACITY = 256;
    localparam int unsigned OVERHEAD       = 6;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [7:0]  TYPE_DATA   = 8'h01;
    localparam logic [7:0]  TYPE_RESULT = 8'h02;
    localparam logic [15:0] LEN_DATA    = 16'd12;
    localparam logic [15:0] LEN_RESULT  = 16'd21;

    localparam int unsigned CNT_W  = 17;
    localparam int unsigned ADDR_W = 3;

    // register indexes
    localparam logic REG_NOTIFY_ENABLE = 1'b0;

    // result kinds
    localparam logic KIND_PAYLOAD  = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_type;
        logic [7:0]  data_byte;
        logic [4:0]  byte_index;
        logic [15:0] frame_length;
        logic        accepted;
        logic        last_payload;
    } t_result;

endpackage

>>> rtl/sync_length_frame_receiver.sv
// Each result is registered in the output register, or in the skid register.
// Throughput: one byte per cycle while the skid register is empty; an output
// register plus a skid register keep s_axis_tready high while one result
// waits on m_axis. Reset (synchronous, i_rst_n low) clears the hunt, header
// state, output valids and notify_enable. Depends on slfr_pkg.
module sync_length_frame_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] frame_type, [15:8] data_byte, [20:16] byte_index,
    // [36:21] frame_length, [37] accepted, [39:38] zero
    output logic [39:0]                   m_axis_tdata,
    output logic                          m_axis_tuser,  // [0] kind
    output logic                          m_axis_tlast,  // last_payload
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slfr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned CW = slfr_pkg::CNT_W;

    logic                r_notify_enable;
    logic                r_synced;
    logic [CW-1:0]       r_byte_count;
    logic [7:0]          r_type;
    logic [15:0]         r_length;
    logic                r_accept;

    logic                n_synced;
    logic [CW-1:0]       n_byte_count;
    logic [7:0]          n_type;
    logic [15:0]         n_length;
    logic                n_accept;

    logic                r_out_valid;
    slfr_pkg::t_result   r_out;
    logic                r_skid_valid;
    slfr_pkg::t_result   r_skid;

    slfr_pkg::t_result   new_res;
    logic                new_valid;
    logic                in_acc;
    logic                out_pop;
    logic                fits;
    logic [CW-1:0]       cnt_inc;
    logic [CW-1:0]       total;
    logic [CW-1:0]       idx_full;
    logic [7:0]          b;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr[2] == slfr_pkg::REG_NOTIFY_ENABLE) ?
                    {31'd0, r_notify_enable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notify_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == slfr_pkg::REG_NOTIFY_ENABLE) begin
            r_notify_enable <= pwdata[0];
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = r_out_valid && m_axis_tready;
    assign b             = s_axis_tdata;

    assign cnt_inc  = r_byte_count + CW'(1);
    assign total    = {1'b0, r_length} + CW'(slfr_pkg::OVERHEAD);
    assign idx_full = cnt_inc - CW'(slfr_pkg::OVERHEAD);
    assign fits     = ({1'b0, b, r_length[7:0]} + CW'(slfr_pkg::OVERHEAD))
                      <= CW'(slfr_pkg::FRAME_CAPACITY);

    always_comb begin
        n_synced     = r_synced;
        n_byte_count = r_byte_count;
        n_type       = r_type;
        n_length     = r_length;
        n_accept     = r_accept;
        new_valid    = 1'b0;
        new_res.kind         = slfr_pkg::KIND_PAYLOAD;
        new_res.frame_type   = r_type;
        new_res.data_byte    = b;
        new_res.byte_index   = idx_full[4:0];
        new_res.frame_length = r_length;
        new_res.accepted     = r_accept;
        new_res.last_payload = (idx_full + CW'(1)) == {1'b0, r_length};

        if (!r_synced) begin
            if (r_byte_count == CW'(0) && b == slfr_pkg::SYNC_FIRST) begin
                n_byte_count = CW'(1);
            end else if (r_byte_count == CW'(1) && b == slfr_pkg::SYNC_SECOND) begin
                n_byte_count = CW'(2);
                n_synced     = 1'b1;
            end else begin
                n_byte_count = CW'(0);
            end
        end else begin
            n_byte_count = cnt_inc;
            if (cnt_inc == CW'(3)) begin
                n_type = b;
            end else if (cnt_inc == CW'(4)) begin
                n_length = {8'd0, b};
            end else if (cnt_inc == CW'(5)) begin
                n_length = {b, r_length[7:0]};
                n_accept = fits &&
                    ((r_type == slfr_pkg::TYPE_DATA && n_length == slfr_pkg::LEN_DATA &&
                      r_notify_enable) ||
                     (r_type == slfr_pkg::TYPE_RESULT &&
                      n_length == slfr_pkg::LEN_RESULT));
            end else if (cnt_inc >= total) begin
                new_valid            = 1'b1;
                new_res.kind         = slfr_pkg::KIND_COMPLETE;
                new_res.data_byte    = 8'd0;
                new_res.byte_index   = 5'd0;
                new_res.last_payload = 1'b0;
                n_synced             = 1'b0;
                n_byte_count         = CW'(0);
            end else if (cnt_inc >= CW'(slfr_pkg::OVERHEAD) && r_accept) begin
                new_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced     <= 1'b0;
            r_byte_count <= '0;
            r_type       <= '0;
            r_length     <= '0;
            r_accept     <= 1'b0;
        end else if (in_acc) begin
            r_synced     <= n_synced;
            r_byte_count <= n_byte_count;
            r_type       <= n_type;
            r_length     <= n_length;
            r_accept     <= n_accept;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc && new_valid;
            end
        end else if (in_acc && new_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            r_out <= r_skid_valid ? r_skid : new_res;
        end
        if (!r_skid_valid) begin
            r_skid <= new_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last_payload;
    assign m_axis_tdata  = {2'b00, r_out.accepted, r_out.frame_length,
                            r_out.byte_index, r_out.data_byte, r_out.frame_type};

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_complete_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == slfr_pkg::KIND_COMPLETE) |->
        (r_out.data_byte == 8'd0 && r_out.byte_index == 5'd0 && !r_out.last_payload))
        else $error("completion word carries payload fields");

    a_last_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_payload) |->
        (r_out.accepted && r_out.kind == slfr_pkg::KIND_PAYLOAD))
        else $error("last payload flag on non-payload word");

    a_hunt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_synced |-> (r_byte_count == CW'(0) || r_byte_count == CW'(1)))
        else $error("hunt counter out of range");

endmodule

>>> tb/sv/slfr_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the sync-word length-prefixed frame receiver: a predictor of the
// hunt/header/payload state plus the queue of result words still owed by the block.
// Depends on slfr_pkg.
package slfr_scoreboard_pkg;

    import slfr_pkg::*;

    class frame_scoreboard;

        logic              notify      = 1'b0;
        logic              synced      = 1'b0;
        logic [CNT_W-1:0]  frame_count = '0;
        logic [7:0]        hdr_type    = '0;
        logic [15:0]       hdr_len     = '0;
        logic              frame_ok    = 1'b0;

        t_result           owed_words[$];
        int unsigned       errors      = 0;
        int unsigned       payload_seen = 0;
        int unsigned       frames_done  = 0;
        int unsigned       frames_kept  = 0;

        function int unsigned owed();
            return owed_words.size();
        endfunction

        function string fmt(t_result r);
            return $sformatf("kind=%0d type=%02h data=%02h idx=%0d len=%0d acc=%0d last=%0d",
                r.kind, r.frame_type, r.data_byte, r.byte_index, r.frame_length,
                r.accepted, r.last_payload);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // advance the frame state by one received byte
        function void note_byte(logic [7:0] b);
            t_result     r;
            int unsigned total;
            int unsigned pos;
            if (!synced) begin
                if (frame_count == 0 && b == SYNC_FIRST) begin
                    frame_count = 1;
                end else if (frame_count == 1 && b == SYNC_SECOND) begin
                    frame_count = 2;
                    synced      = 1'b1;
                end else begin
                    frame_count = 0;
                end
                return;
            end
            frame_count = frame_count + 1'b1;
            if (frame_count == 3) begin
                hdr_type = b;
                return;
            end
            if (frame_count == 4) begin
                hdr_len = {8'h00, b};
                return;
            end
            if (frame_count == 5) begin
                hdr_len[15:8] = b;
                frame_ok = ((hdr_len + OVERHEAD) <= FRAME_CAPACITY) &&
                           ((hdr_type == TYPE_DATA && hdr_len == LEN_DATA && notify) ||
                            (hdr_type == TYPE_RESULT && hdr_len == LEN_RESULT));
                return;
            end
            total          = hdr_len + OVERHEAD;
            r.frame_type   = hdr_type;
            r.frame_length = hdr_len;
            r.accepted     = frame_ok;
            if (frame_count >= total) begin
                r.kind         = KIND_COMPLETE;
                r.data_byte    = '0;
                r.byte_index   = '0;
                r.last_payload = 1'b0;
                owed_words.push_back(r);
                synced      = 1'b0;
                frame_count = '0;
            end else if (frame_count >= OVERHEAD && frame_ok) begin
                pos            = frame_count - OVERHEAD;
                r.kind         = KIND_PAYLOAD;
                r.data_byte    = b;
                r.byte_index   = pos[4:0];
                r.last_payload = (pos + 1 == hdr_len);
                owed_words.push_back(r);
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (owed_words.size() == 0) begin
                flag($sformatf("mismatch: unexpected word %s", fmt(got)));
                return;
            end
            want = owed_words.pop_front();
            if (got.kind !== want.kind || got.frame_type !== want.frame_type ||
                got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
                got.frame_length !== want.frame_length || got.accepted !== want.accepted ||
                got.last_payload !== want.last_payload) begin
                flag($sformatf("mismatch: expected %s\n          got      %s",
                    fmt(want), fmt(got)));
            end
            if (want.kind == KIND_COMPLETE) begin
                frames_done++;
                if (want.accepted) frames_kept++;
            end else begin
                payload_seen++;
            end
        endfunction

    endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for sync_length_frame_receiver: drives byte streams and
// APB writes, checks every result word against the scoreboard's predictor.
// Depends on slfr_pkg, slfr_scoreboard_pkg and the RTL.
module tb_top;

    import slfr_pkg::*;
    import slfr_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [ADDR_W-1:0] ADDR_NOTIFY = ADDR_W'(4 * REG_NOTIFY_ENABLE);
    localparam logic [ADDR_W-1:0] ADDR_SPARE  = ADDR_W'(4);

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    frame_scoreboard    sb = new();
    t_result            seen_word;
    int unsigned        src_idle_pct  = 19;
    int unsigned        sink_idle_pct = 60;
    int unsigned        cycle_count   = 0;
    int unsigned        bytes_sent    = 0;
    int unsigned        frame_bytes   = 0;
    int unsigned        frames_sent   = 0;

    sync_length_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed", cycle_count, sb.owed());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            seen_word.kind         = m_axis_tuser;
            seen_word.frame_type   = m_axis_tdata[7:0];
            seen_word.data_byte    = m_axis_tdata[15:8];
            seen_word.byte_index   = m_axis_tdata[20:16];
            seen_word.frame_length = m_axis_tdata[36:21];
            seen_word.accepted     = m_axis_tdata[37];
            seen_word.last_payload = m_axis_tlast;
            sb.check_word(seen_word);
        end
    end

    // all tasks are entered and left just after a falling edge
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == ADDR_NOTIFY) sb.notify = value[0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) @(negedge i_clk);
        s_axis_tdata  = b;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(ftype);
        send_byte(flen[7:0]);
        send_byte(flen[15:8]);
        for (int i = 0; i < flen; i++) send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));  // trailing byte
        frame_bytes += flen + OVERHEAD;
        frames_sent++;
    endtask

    // hunt-state noise; always leaves the hunt back at its start
    task automatic send_noise();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        case ($urandom_range(2))
            0: begin
                if (b == SYNC_FIRST) b = 8'h00;
                send_byte(b);
            end
            1: begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
            end
            default: begin
                if (b == SYNC_FIRST || b == SYNC_SECOND) b = 8'hA5;
                send_byte(SYNC_FIRST);
                send_byte(b);
            end
        endcase
    endtask

    task automatic send_random_frame();
        logic [7:0]  ftype;
        logic [15:0] flen;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4) ftype = TYPE_DATA;
        else if (pick < 7) ftype = TYPE_RESULT;
        else ftype = 8'($urandom_range(255));
        if ($urandom_range(49) == 0) flen = 16'($urandom_range(245, 260));
        else if (ftype == TYPE_DATA && $urandom_range(4) != 0) flen = LEN_DATA;
        else if (ftype == TYPE_RESULT && $urandom_range(4) != 0) flen = LEN_RESULT;
        else flen = 16'($urandom_range(30));
        send_frame(ftype, flen);
    endtask

    task automatic run_random(input int unsigned n_bytes);
        int unsigned target;
        target = frame_bytes + n_bytes;
        while (frame_bytes < target) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_random_frame();
        end
    endtask

    task automatic wait_drained();
        while (sb.owed() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // unmapped address must not touch notify_enable
        reg_write(ADDR_SPARE, 32'h0000_0001);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_frame(8'hFF, 16'h0000);
        send_frame(TYPE_DATA, LEN_DATA);
        wait_drained();

        reg_write(ADDR_NOTIFY, 32'h0000_0001);
        run_random(500);
        wait_drained();

        src_idle_pct  = 60;
        sink_idle_pct = 19;
        reg_write(ADDR_NOTIFY, 32'h0000_0000);
        run_random(500);
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        reg_write(ADDR_NOTIFY, 32'hFFFF_FFFF);
        send_frame(8'($urandom_range(255)), 16'd251);
        run_random(270);
        wait_drained();
        repeat (10) @(negedge i_clk);

        $display("sent %0d bytes in %0d frames; checked %0d payload words, %0d completions",
            bytes_sent, frames_sent, sb.payload_seen, sb.frames_done);
        $display("%0d frames accepted, %0d mismatches", sb.frames_kept, sb.errors);
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/slfr_pkg.sv
rtl/sync_length_frame_receiver.sv
tb/sv/slfr_scoreboard_pkg.sv
tb/sv/tb_top.sv
